>>> rtl/cubic_spline_point_eval_unit_assert.svh
// Assertion macros for the cubic spline point evaluator
`ifndef CUBIC_SPLINE_POINT_EVAL_UNIT_ASSERT_SVH
`define CUBIC_SPLINE_POINT_EVAL_UNIT_ASSERT_SVH

// expr must hold at every clock edge outside reset
`define CSPE_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// trig implies expr at the same edge
`define CSPE_ASSERT_IMP(name, trig, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |-> (expr)) else $error(msg);

`endif

>>> rtl/cspe_pkg.sv
// Shared types, constants and functions of the cubic spline point evaluator
package cspe_pkg;

  localparam int MaxPoints = 1024;
  localparam int IdxBits   = 10;
  localparam int CntBits   = 11;
  localparam int CoordBits = 20;
  localparam int TanBits   = 23;
  localparam int TBits     = 17;

  localparam logic [1:0] KIND_LINEAR  = 2'd0;
  localparam logic [1:0] KIND_CATROM  = 2'd1;
  localparam logic [1:0] KIND_BSPLINE = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_CURVE_KIND  = 1'b1;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [TanBits-1:0]   tanv_t;
  typedef logic signed [31:0]          hval_t;
  typedef logic [3*CoordBits-1:0]      pt_t;
  typedef logic [IdxBits-1:0]          idx_t;

  typedef struct packed {
    logic             vld;
    logic             eval;
    logic             bad;
    logic [1:0]       kind;
    logic [TBits-1:0] t;
  } ctl_t;

  // basis weights [kind][point][power t^3, t^2, t, 1], scaled by 1, 2 or 6
  localparam logic signed [3:0] WT [3][4][4] = '{
    '{'{4'sd0, 4'sd0, 4'sd0, 4'sd0}, '{4'sd0, 4'sd0, -4'sd1, 4'sd1},
      '{4'sd0, 4'sd0, 4'sd1, 4'sd0}, '{4'sd0, 4'sd0, 4'sd0, 4'sd0}},
    '{'{-4'sd1, 4'sd2, -4'sd1, 4'sd0}, '{4'sd3, -4'sd5, 4'sd0, 4'sd2},
      '{-4'sd3, 4'sd4, 4'sd1, 4'sd0}, '{4'sd1, -4'sd1, 4'sd0, 4'sd0}},
    '{'{-4'sd1, 4'sd3, -4'sd3, 4'sd1}, '{4'sd3, -4'sd6, 4'sd0, 4'sd4},
      '{-4'sd3, 4'sd3, 4'sd3, 4'sd1}, '{4'sd1, 4'sd0, 4'sd0, 4'sd0}}
  };

  function automatic logic signed [3:0] wt(logic [1:0] kind, int k, int j);
    logic signed [3:0] w;
    w = 4'sd0;
    case (kind)
      KIND_LINEAR:  w = WT[0][k][j];
      KIND_CATROM:  w = WT[1][k][j];
      KIND_BSPLINE: w = WT[2][k][j];
      default:      w = 4'sd0;
    endcase
    return w;
  endfunction

  function automatic coord_t axis_of(pt_t p, int a);
    return coord_t'(p[a*CoordBits +: CoordBits]);
  endfunction

  // h * t / 2^16 rounded half up, plus next
  function automatic hval_t hstep(hval_t h, logic [TBits-1:0] t, hval_t nx);
    logic signed [49:0] p;
    logic signed [49:0] r;
    p = h * $signed({1'b0, t});
    r = (p + 50'sd32768) >>> 16;
    return $signed(r[31:0]) + nx;
  endfunction

endpackage

>>> rtl/cspe_fetch.sv
// Neighbour index generation and four-bank control point store
module cspe_fetch
  import cspe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic                 in_mode,
  input  idx_t                 in_widx,
  input  pt_t                  in_pt,
  input  idx_t                 in_seg,
  input  logic [TBits-1:0]     in_t,
  input  logic [CntBits-1:0]   point_count,
  input  logic [1:0]           curve_kind,
  output ctl_t                 ctl1,
  output pt_t                  pts [4]
);

  logic [CntBits-1:0] nc;
  logic [CntBits-1:0] seg_e;
  logic [CntBits-1:0] s1;
  logic [CntBits-1:0] s2;
  idx_t               idx_next [4];
  ctl_t               ctl0;
  idx_t               idx0 [4];
  idx_t               widx0;
  pt_t                wdat0;

  always_comb begin
    if (point_count < CntBits'(4)) nc = CntBits'(4);
    else if (point_count > CntBits'(MaxPoints)) nc = CntBits'(MaxPoints);
    else nc = point_count;
    seg_e = {1'b0, in_seg};
    s1 = seg_e + CntBits'(1);
    s2 = seg_e + CntBits'(2);
    idx_next[0] = (in_seg == '0) ? idx_t'(nc - CntBits'(1)) : idx_t'(seg_e - CntBits'(1));
    idx_next[1] = in_seg;
    idx_next[2] = (s1 == nc) ? '0 : idx_t'(s1);
    idx_next[3] = (s2 >= nc) ? idx_t'(s2 - nc) : idx_t'(s2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl0 <= '0;
    end else if (en) begin
      ctl0.vld  <= in_vld;
      ctl0.eval <= in_mode;
      ctl0.bad  <= seg_e >= nc;
      ctl0.kind <= curve_kind;
      ctl0.t    <= in_t;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx0  <= idx_next;
      widx0 <= in_widx;
      wdat0 <= in_pt;
    end
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    pt_t mem [MaxPoints];
    always_ff @(posedge clk) begin
      if (en && ctl0.vld && !ctl0.eval) mem[widx0] <= wdat0;
      if (en) pts[b] <= mem[idx0[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ctl1 <= '0;
    else if (en) ctl1 <= ctl0;
  end

endmodule

>>> rtl/cspe_coef.sv
// Per-power polynomial coefficients from the four gathered points
module cspe_coef
  import cspe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  ctl_t  ctl1,
  input  pt_t   pts [4],
  output ctl_t  ctl2,
  output hval_t coef [3][4]
);

  hval_t coef_next [3][4];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 4; j++) begin
        coef_next[a][j] = '0;
        for (int k = 0; k < 4; k++) begin
          coef_next[a][j] = coef_next[a][j]
                            + hval_t'(axis_of(pts[k], a) * wt(ctl1.kind, k, j));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) coef <= coef_next;
  end

  always_ff @(posedge clk) begin
    if (rst) ctl2 <= '0;
    else if (en) ctl2 <= ctl1;
  end

endmodule

>>> rtl/cspe_horner.sv
// Three Horner stages for position and two for tangent
module cspe_horner
  import cspe_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  ctl_t  ctl2,
  input  hval_t coef [3][4],
  output ctl_t  ctl5,
  output hval_t hp [3],
  output hval_t ht [3]
);

  ctl_t  ctl3;
  ctl_t  ctl4;
  hval_t hp3 [3];
  hval_t ht3 [3];
  hval_t c3 [3];
  hval_t d3 [3];
  hval_t hp4 [3];
  hval_t ht4 [3];
  hval_t d4 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        hp3[a] <= hstep(coef[a][0], ctl2.t, coef[a][1]);
        ht3[a] <= hstep(3 * coef[a][0], ctl2.t, coef[a][1] <<< 1);
        c3[a]  <= coef[a][2];
        d3[a]  <= coef[a][3];
        hp4[a] <= hstep(hp3[a], ctl3.t, c3[a]);
        ht4[a] <= hstep(ht3[a], ctl3.t, c3[a]);
        d4[a]  <= d3[a];
        hp[a]  <= hstep(hp4[a], ctl4.t, d4[a]);
        ht[a]  <= ht4[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
      ctl4 <= '0;
      ctl5 <= '0;
    end else if (en) begin
      ctl3 <= ctl2;
      ctl4 <= ctl3;
      ctl5 <= ctl4;
    end
  end

endmodule

>>> rtl/cspe_scale.sv
// Basis denominator, rounding and saturation to the result fields
module cspe_scale
  import cspe_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  ctl_t   ctl5,
  input  hval_t  hp [3],
  input  hval_t  ht [3],
  output ctl_t   ctl7,
  output coord_t pos [3],
  output tanv_t  tanv [3]
);

  localparam logic [31:0] Recip3 = 32'hAAAAAAAB;
  localparam hval_t       Bias   = 32'sd268435456;

  ctl_t  ctl6;
  hval_t vp [3];
  hval_t vt [3];

  function automatic hval_t prep(hval_t h, logic [1:0] kind);
    hval_t v;
    case (kind)
      KIND_LINEAR: v = h;
      KIND_CATROM: v = (h + 32'sd1) >>> 1;
      default:     v = (h + 32'sd3) >>> 1;
    endcase
    return v;
  endfunction

  // floor(v / 3) by reciprocal on a biased, non-negative operand
  function automatic hval_t div3(hval_t v);
    logic [31:0] u;
    logic [63:0] p;
    u = 32'(v + 3 * Bias);
    p = {32'b0, u} * {32'b0, Recip3};
    return $signed({1'b0, p[63:33]}) - Bias;
  endfunction

  function automatic hval_t fin(hval_t v, logic [1:0] kind);
    return (kind == KIND_BSPLINE) ? div3(v) : v;
  endfunction

  function automatic coord_t satp(hval_t v, logic zero);
    coord_t r;
    if (zero) r = '0;
    else if (v > 32'sd524287) r = 20'sh7FFFF;
    else if (v < -32'sd524288) r = 20'sh80000;
    else r = coord_t'(v);
    return r;
  endfunction

  function automatic tanv_t satt(hval_t v, logic zero);
    tanv_t r;
    if (zero) r = '0;
    else if (v > 32'sd4194303) r = 23'sh3FFFFF;
    else if (v < -32'sd4194304) r = 23'sh400000;
    else r = tanv_t'(v);
    return r;
  endfunction

  logic zero6;
  assign zero6 = ctl6.bad || (ctl6.kind != KIND_LINEAR && ctl6.kind != KIND_CATROM
                              && ctl6.kind != KIND_BSPLINE);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        vp[a]   <= prep(hp[a], ctl5.kind);
        vt[a]   <= prep(ht[a], ctl5.kind);
        pos[a]  <= satp(fin(vp[a], ctl6.kind), zero6);
        tanv[a] <= satt(fin(vt[a], ctl6.kind), zero6);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl6 <= '0;
      ctl7 <= '0;
    end else if (en) begin
      ctl6 <= ctl5;
      ctl7 <= ctl6;
    end
  end

endmodule

>>> rtl/cubic_spline_point_eval_unit.sv
// Cubic spline point evaluator: takes one item per clock while the output is not
// stalled; each item runs through the eight-stage pipeline (index, store read,
// coefficients, three Horner steps, denominator, saturation). Write items pass
// through without a result. A stall at the output holds every stage at once.
module cubic_spline_point_eval_unit
  import cspe_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [103:0]  s_axis_tdata,   // write_index, point_x, point_y, point_z, segment, t_param
  input  logic          s_axis_tuser,   // mode
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [135:0]  m_axis_tdata,   // pos_x, pos_y, pos_z, tan_x, tan_y, tan_z
  output logic          m_axis_tuser,   // bad_segment
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [10:0]   cfg_data
);

  `include "cubic_spline_point_eval_unit_assert.svh"

  logic               en;
  logic [CntBits-1:0] point_count;
  logic [1:0]         curve_kind;
  ctl_t               ctl1, ctl2, ctl5, ctl7;
  pt_t                pts [4];
  hval_t              coef [3][4];
  hval_t              hp [3];
  hval_t              ht [3];
  coord_t             pos [3];
  tanv_t              tanv [3];

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CntBits'(4);
      curve_kind  <= KIND_CATROM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINT_COUNT: point_count <= cfg_data;
        CFG_CURVE_KIND:  curve_kind  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  cspe_fetch u_fetch (
    .clk, .rst, .en,
    .in_vld      (s_axis_tvalid && s_axis_tready),
    .in_mode     (s_axis_tuser),
    .in_widx     (s_axis_tdata[9:0]),
    .in_pt       (s_axis_tdata[69:10]),
    .in_seg      (s_axis_tdata[79:70]),
    .in_t        (s_axis_tdata[96:80]),
    .point_count (point_count),
    .curve_kind  (curve_kind),
    .ctl1        (ctl1),
    .pts         (pts)
  );

  cspe_coef u_coef (.clk, .rst, .en, .ctl1, .pts, .ctl2, .coef);

  cspe_horner u_horner (.clk, .rst, .en, .ctl2, .coef, .ctl5, .hp, .ht);

  cspe_scale u_scale (.clk, .rst, .en, .ctl5, .hp, .ht, .ctl7, .pos, .tanv);

  assign m_axis_tvalid = ctl7.vld && ctl7.eval;
  assign m_axis_tuser  = ctl7.bad;
  assign m_axis_tdata  = {7'b0, tanv[2], tanv[1], tanv[0], pos[2], pos[1], pos[0]};

  `CSPE_ASSERT_IMP(a_bad_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0,
                   "bad segment result carries non-zero data")
  `CSPE_ASSERT_IMP(a_stall_only_full, !s_axis_tready, m_axis_tvalid,
                   "input stalled with no result waiting")
  `CSPE_ASSERT_IMP(a_kind3_zero,
                   m_axis_tvalid && !m_axis_tuser && curve_kind == KIND_NONE,
                   m_axis_tdata == '0, "unknown curve kind gave non-zero result")

endmodule
